// ===== hw/rtl/u2u_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types, codes and helpers of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

  localparam int unsigned CountBits = 16;
  localparam logic [15:0] CAP_MAX = (CountBits >= 16) ? 16'hFFFF :
                                    16'((32'd1 << CountBits) - 32'd1);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic {
    CFG_BIG_ENDIAN,
    CFG_OUT_CAPACITY
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_INVALID,
    ST_RANGE,
    ST_TRUNC,
    ST_FULL
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic        is_terminator;
    status_t     status;
    logic [15:0] word_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  ndata;
    logic        term;
    status_t     status;
    logic [15:0] wc_base;
    logic        term_incr;
    logic [15:0] w0;
    logic [15:0] w1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [30:0] min_for_len(input logic [2:0] len);
    logic [30:0] m;
    case (len)
      3'd2:    m = 31'h80;
      3'd3:    m = 31'h800;
      3'd4:    m = 31'h10000;
      3'd5:    m = 31'h200000;
      3'd6:    m = 31'h4000000;
      default: m = 31'h0;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] order_word(input logic [15:0] w, input logic be);
    return be ? {w[7:0], w[15:8]} : w;
  endfunction

endpackage

// ===== hw/rtl/utf8_to_utf16_transcoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Flow: an accepted byte's command is written to the command queue; its first
// result shows once the command is at the head. One byte per cycle while the
// queue is not full; the 4-entry queue after decode absorbs extra results.
// Reset: synchronous, active low; clears string state and queue, sets
// big_endian to 0 and output_capacity to 65535.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core import u2u_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    cmd;
  cmd_t    head;

  u2u_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (cmd)
  );

  u2u_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .cmd_in(cmd),
    .pop   (pop),
    .head  (head),
    .q_stat(q_stat)
  );

  u2u_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/u2u_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_front
// Accepts UTF-8 bytes, decodes code points, checks them and issues one
// command per byte that yields results. Holds the configuration registers.
// ----------------------------------------------------------------------------
module u2u_front import u2u_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  q_stat_t     q_stat,
  output logic        push,
  output cmd_t        cmd
);

  logic        be_r;
  logic [15:0] cap_r;
  logic [30:0] acc_r, acc_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [2:0]  rcv_r, rcv_nxt;
  logic [15:0] ww_r, ww_nxt;
  logic        halted_r, halted_nxt;

  logic [15:0] cap;
  logic [15:0] free_w;
  logic        pair;
  logic [19:0] v;
  status_t     st;
  logic [1:0]  ndata;
  logic        term;
  logic        term_incr;
  logic [15:0] w0, w1;
  logic [7:0]  b;
  logic        eos;
  logic        fire;

  assign b        = in_data.in_byte;
  assign eos      = in_data.end_of_string;
  assign in_ready = !q_stat.full;
  assign fire     = in_valid && in_ready;
  assign cap      = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign free_w   = (ww_r < cap) ? 16'(cap - ww_r) : 16'd0;

  always_comb begin
    acc_nxt    = acc_r;
    len_nxt    = len_r;
    rcv_nxt    = rcv_r;
    ww_nxt     = ww_r;
    halted_nxt = halted_r;
    st         = ST_OK;
    ndata      = 2'd0;
    term       = 1'b0;
    term_incr  = 1'b0;
    w0         = 16'd0;
    w1         = 16'd0;
    pair       = 1'b0;
    v          = 20'd0;
    if (halted_r) begin
      if (eos) begin
        acc_nxt    = '0;
        len_nxt    = '0;
        rcv_nxt    = '0;
        ww_nxt     = '0;
        halted_nxt = 1'b0;
      end
    end else begin
      if (len_r == 3'd0) begin
        case (b) inside
          [8'h00:8'h7F]: begin acc_nxt = {23'd0, b};      len_nxt = 3'd1; end
          [8'hC0:8'hDF]: begin acc_nxt = {26'd0, b[4:0]}; len_nxt = 3'd2; end
          [8'hE0:8'hEF]: begin acc_nxt = {27'd0, b[3:0]}; len_nxt = 3'd3; end
          [8'hF0:8'hF7]: begin acc_nxt = {28'd0, b[2:0]}; len_nxt = 3'd4; end
          [8'hF8:8'hFB]: begin acc_nxt = {29'd0, b[1:0]}; len_nxt = 3'd5; end
          [8'hFC:8'hFD]: begin acc_nxt = {30'd0, b[0]};   len_nxt = 3'd6; end
          default:       st = ST_INVALID;
        endcase
        rcv_nxt = (st == ST_OK) ? 3'd1 : 3'd0;
      end else if (b[7:6] != 2'b10) begin
        st = ST_INVALID;
      end else begin
        acc_nxt = {acc_r[24:0], b[5:0]};
        rcv_nxt = 3'(rcv_r + 3'd1);
      end

      if (st == ST_OK && len_nxt != 3'd0 && rcv_nxt >= len_nxt) begin
        if (acc_nxt < min_for_len(len_nxt)) begin
          st = ST_INVALID;
        end else if (acc_nxt >= 31'h110000) begin
          st = ST_RANGE;
        end else begin
          pair = (acc_nxt >= 31'h10000);
          if (pair ? (free_w < 16'd2) : (free_w == 16'd0)) begin
            st = ST_FULL;
          end else if (pair) begin
            v      = 20'(acc_nxt[20:0] - 21'h010000);
            w0     = order_word(16'hD800 + {6'd0, v[19:10]}, be_r);
            w1     = order_word(16'hDC00 + {6'd0, v[9:0]}, be_r);
            ndata  = 2'd2;
            ww_nxt = 16'(ww_r + 16'd2);
          end else begin
            w0     = order_word(acc_nxt[15:0], be_r);
            ndata  = 2'd1;
            ww_nxt = 16'(ww_r + 16'd1);
          end
        end
        acc_nxt = '0;
        len_nxt = '0;
        rcv_nxt = '0;
      end

      if (st == ST_OK && eos) begin
        if (len_nxt != 3'd0) begin
          st = ST_TRUNC;
        end else if (ww_nxt >= cap) begin
          st = ST_FULL;
        end
      end

      if (st != ST_OK || eos) begin
        term      = 1'b1;
        term_incr = (ww_nxt < cap);
        acc_nxt   = '0;
        len_nxt   = '0;
        rcv_nxt   = '0;
        if (eos) begin
          ww_nxt     = '0;
          halted_nxt = 1'b0;
        end else begin
          halted_nxt = 1'b1;
        end
      end
    end
  end

  assign push          = fire && (ndata != 2'd0 || term);
  assign cmd.ndata     = ndata;
  assign cmd.term      = term;
  assign cmd.status    = st;
  assign cmd.wc_base   = ww_r;
  assign cmd.term_incr = term_incr;
  assign cmd.w0        = w0;
  assign cmd.w1        = w1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      be_r     <= 1'b0;
      cap_r    <= 16'hFFFF;
      acc_r    <= '0;
      len_r    <= '0;
      rcv_r    <= '0;
      ww_r     <= '0;
      halted_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BIG_ENDIAN:   be_r  <= cfg_wdata[0];
          CFG_OUT_CAPACITY: cap_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (fire) begin
        acc_r    <= acc_nxt;
        len_r    <= len_nxt;
        rcv_r    <= rcv_nxt;
        ww_r     <= ww_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  a_halt_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (len_r == 3'd0 && rcv_r == 3'd0 && acc_r == 31'd0))
    else $error("sequence state left open while halted");

endmodule

// ===== hw/rtl/u2u_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_cmdq
// Short command queue between the decode front and the output back end.
// ----------------------------------------------------------------------------
module u2u_cmdq import u2u_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    cmd_in,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = (QPTR_W+1)'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = (QPTR_W+1)'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && q_stat.full))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("command queue underflow");

endmodule

// ===== hw/rtl/u2u_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_back
// Expands each queued command into its data words and any terminator, one
// output transaction per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module u2u_back import u2u_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic [1:0] total;
  logic       last_item;
  logic       is_data;

  assign total     = 2'(head.ndata + {1'b0, head.term});
  assign last_item = (idx_r == 2'(total - 2'd1));
  assign is_data   = (idx_r < head.ndata);
  assign out_valid = !q_stat.empty;
  assign pop       = out_valid && out_ready && last_item;

  always_comb begin
    if (is_data) begin
      out_data.out_word      = (idx_r == 2'd0) ? head.w0 : head.w1;
      out_data.is_terminator = 1'b0;
      out_data.status        = ST_OK;
      out_data.word_count    = 16'(head.wc_base + {14'd0, idx_r} + 16'd1);
      out_data.last          = 1'b0;
    end else begin
      out_data.out_word      = 16'd0;
      out_data.is_terminator = 1'b1;
      out_data.status        = head.status;
      out_data.word_count    = 16'(head.wc_base + {14'd0, head.ndata} +
                                   {15'd0, head.term_incr});
      out_data.last          = 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) begin
      idx_nxt = last_item ? 2'd0 : 2'(idx_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r < total))
    else $error("result index beyond command");

  a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> (idx_r == 2'd0))
    else $error("result index not cleared with queue empty");

endmodule

// ===== verif/tb_utf8_to_utf16_transcoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder_core
// Self-checking bench for the UTF-8 to UTF-16 transcoder. A short directed
// script covers the common lead byte classes and the invalid, range and
// truncation errors. It is followed by random strings, mostly well-formed with
// some broken sequences and noise, under several byte-order and capacity
// settings. Every accepted output transaction is compared field by field
// against an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_transcoder_core;
  import u2u_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned PHASE_BYTES    = 36;
  localparam int unsigned NUM_PHASES     = 8;

  typedef struct {
    logic [7:0]  b;
    logic        eos;
    logic        typed;
    status_t     st;
    logic [15:0] wc;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  // decoder model state and register shadow
  logic [30:0] acc;
  logic [2:0]  seq_len;
  logic [2:0]  nrecv;
  logic [15:0] wcount;
  logic        halted;
  logic        cfg_be;
  logic [15:0] cfg_cap;

  out_item_t   words_due[$];
  out_item_t   step_out[$];
  in_item_t    text_q[$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  int          idle_pct = 20;

  script_row_t script [23] = '{
    '{8'h00, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'h7F, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'hDF, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'hBF, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'hED, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'hA0, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'hF4, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'h8F, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'hBF, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'hBF, 1'b1, 1'b0, ST_OK,      16'd0},
    '{8'h80, 1'b0, 1'b1, ST_INVALID, 16'd1},  // stray continuation
    '{8'h41, 1'b1, 1'b0, ST_OK,      16'd0},  // halted, dropped
    '{8'hFF, 1'b1, 1'b1, ST_INVALID, 16'd1},
    '{8'hC0, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'h80, 1'b1, 1'b1, ST_INVALID, 16'd1},  // overlong
    '{8'hF4, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'h90, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'h80, 1'b1, 1'b1, ST_RANGE,   16'd1},
    '{8'hE2, 1'b1, 1'b1, ST_TRUNC,   16'd1},
    '{8'hC2, 1'b0, 1'b0, ST_OK,      16'd0},
    '{8'h41, 1'b1, 1'b1, ST_INVALID, 16'd1}   // missing continuation
  };

  utf8_to_utf16_transcoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: word %h term %b status %0d count %0d last %b",
                   out_data.out_word, out_data.is_terminator, out_data.status,
                   out_data.word_count, out_data.last);
      end else begin
        want = words_due.pop_front();
        if (out_data.out_word !== want.out_word ||
            out_data.is_terminator !== want.is_terminator ||
            out_data.status !== want.status ||
            out_data.word_count !== want.word_count ||
            out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch (exp/act): word %h/%h term %b/%b status %0d/%0d ",
                      "count %0d/%0d last %b/%b"},
                     want.out_word, out_data.out_word,
                     want.is_terminator, out_data.is_terminator,
                     want.status, out_data.status,
                     want.word_count, out_data.word_count,
                     want.last, out_data.last);
        end
      end
    end
  end

  function automatic void clear_string();
    acc     = '0;
    seq_len = '0;
    nrecv   = '0;
    wcount  = '0;
    halted  = 1'b0;
  endfunction

  function automatic void emit_unit(input logic [15:0] w);
    out_item_t r;
    wcount          = wcount + 16'd1;
    r.out_word      = cfg_be ? {w[7:0], w[15:8]} : w;
    r.is_terminator = 1'b0;
    r.status        = ST_OK;
    r.word_count    = wcount;
    r.last          = 1'b0;
    step_out.push_back(r);
  endfunction

  // Advances the decoder model by one byte, leaving its results in step_out.
  function automatic void decode_byte(input in_item_t it);
    status_t     st;
    logic [30:0] floor_cp;
    logic [30:0] v;
    logic [16:0] room;
    out_item_t   r;
    st = ST_OK;
    step_out.delete();
    if (halted) begin
      if (it.end_of_string) clear_string();
      return;
    end
    if (seq_len == 0) begin
      if (it.in_byte < 8'h80) begin
        acc = 31'(it.in_byte); seq_len = 3'd1;
      end else if (it.in_byte < 8'hC0) begin
        st = ST_INVALID;
      end else if (it.in_byte < 8'hE0) begin
        acc = 31'(it.in_byte & 8'h1F); seq_len = 3'd2;
      end else if (it.in_byte < 8'hF0) begin
        acc = 31'(it.in_byte & 8'h0F); seq_len = 3'd3;
      end else if (it.in_byte < 8'hF8) begin
        acc = 31'(it.in_byte & 8'h07); seq_len = 3'd4;
      end else if (it.in_byte < 8'hFC) begin
        acc = 31'(it.in_byte & 8'h03); seq_len = 3'd5;
      end else if (it.in_byte < 8'hFE) begin
        acc = 31'(it.in_byte & 8'h01); seq_len = 3'd6;
      end else begin
        st = ST_INVALID;
      end
      nrecv = (st == ST_OK) ? 3'd1 : 3'd0;
    end else if (it.in_byte[7:6] != 2'b10) begin
      st = ST_INVALID;
    end else begin
      acc   = {acc[24:0], it.in_byte[5:0]};
      nrecv = nrecv + 3'd1;
    end

    if (st == ST_OK && seq_len != 0 && nrecv >= seq_len) begin
      case (seq_len)
        3'd2:    floor_cp = 31'h80;
        3'd3:    floor_cp = 31'h800;
        3'd4:    floor_cp = 31'h10000;
        3'd5:    floor_cp = 31'h200000;
        3'd6:    floor_cp = 31'h4000000;
        default: floor_cp = 31'h0;
      endcase
      room = (wcount < cfg_cap) ? 17'(cfg_cap - wcount) : 17'd0;
      if (seq_len > 3'd6 || acc < floor_cp) begin
        st = ST_INVALID;
      end else if (acc >= 31'h110000) begin
        st = ST_RANGE;
      end else if (acc >= 31'h10000) begin
        if (room < 17'd2) begin
          st = ST_FULL;
        end else begin
          v = acc - 31'h10000;
          emit_unit(16'hD800 + 16'(v[19:10]));
          emit_unit(16'hDC00 + 16'(v[9:0]));
        end
      end else if (room < 17'd1) begin
        st = ST_FULL;
      end else begin
        emit_unit(acc[15:0]);
      end
      seq_len = '0;
      nrecv   = '0;
      acc     = '0;
    end

    if (st == ST_OK && it.end_of_string) begin
      if (seq_len != 0) st = ST_TRUNC;
      else if (wcount >= cfg_cap) st = ST_FULL;
    end

    if (st != ST_OK || it.end_of_string) begin
      if (wcount < cfg_cap) wcount = wcount + 16'd1;
      r.out_word      = 16'h0000;
      r.is_terminator = 1'b1;
      r.status        = st;
      r.word_count    = wcount;
      r.last          = 1'b1;
      step_out.push_back(r);
      if (it.end_of_string) begin
        clear_string();
      end else begin
        seq_len = '0;
        nrecv   = '0;
        acc     = '0;
        halted  = 1'b1;
      end
    end
  endfunction

  task automatic send_byte(input in_item_t it, input logic typed, input out_item_t want);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    decode_byte(it);
    if (typed) words_due.push_back(want);
    else foreach (step_out[i]) words_due.push_back(step_out[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BIG_ENDIAN) cfg_be = val[0];
    else cfg_cap = val;
    @(posedge clk);
  endtask

  // Appends one random string to text_q: mostly well-formed code points,
  // sometimes truncated, with stray bytes inserted, or plain noise.
  task automatic build_string();
    logic [7:0]  bytes_q[$];
    int          kind;
    int          len;
    int          pick;
    logic [30:0] cp;
    logic [7:0]  lead;
    in_item_t    it;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4)) bytes_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        kind = $urandom_range(99);
        len  = 1;
        cp   = '0;
        if (kind < 30) begin
          cp = 31'($urandom_range(0, 'h7F));
        end else if (kind < 50) begin
          len = 2; cp = 31'($urandom_range('h80, 'h7FF));
        end else if (kind < 65) begin
          len = 3; cp = 31'($urandom_range('h800, 'hFFFF));
        end else if (kind < 80) begin
          len = 4; cp = 31'($urandom_range('h10000, 'h10FFFF));
        end else if (kind < 84) begin
          len = 4; cp = 31'($urandom_range('h110000, 'h1FFFFF));
        end else if (kind < 88) begin
          len = 5; cp = 31'($urandom_range(0, 'h3FFFFFF));
        end else if (kind < 92) begin
          len = 6; cp = 31'($urandom);
        end else if (kind < 96) begin
          len = $urandom_range(2, 4); cp = 31'($urandom_range(0, 'h7F));
        end else begin
          len = 0;
          bytes_q.push_back(8'($urandom));
        end
        if (len == 1) begin
          bytes_q.push_back(cp[7:0]);
        end else if (len > 1) begin
          lead = 8'(8'hFF << (8 - len)) | (8'(cp >> (6 * (len - 1))) & (8'hFF >> (len + 1)));
          bytes_q.push_back(lead);
          for (int i = len - 2; i >= 0; i--)
            bytes_q.push_back(8'h80 | (8'(cp >> (6 * i)) & 8'h3F));
        end
      end
      pick = $urandom_range(99);
      if (pick < 8 && bytes_q.size() > 1)
        void'(bytes_q.pop_back());
      else if (pick < 16)
        bytes_q.insert($urandom_range(0, bytes_q.size() - 1), 8'($urandom));
    end
    foreach (bytes_q[i]) begin
      it.in_byte       = bytes_q[i];
      it.end_of_string = (i == bytes_q.size() - 1);
      text_q.push_back(it);
    end
  endtask

  initial begin
    in_item_t    it;
    out_item_t   want;
    int          sent;
    logic [15:0] caps [NUM_PHASES];
    logic        orders [NUM_PHASES];
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_be  = 1'b0;
    cfg_cap = 16'hFFFF;
    clear_string();
    caps   = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 12)),
               16'($urandom_range(100, 65534)), 16'hFFFF};
    orders = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      it.in_byte         = script[i].b;
      it.end_of_string   = script[i].eos;
      want.out_word      = 16'h0000;
      want.is_terminator = 1'b1;
      want.status        = script[i].st;
      want.word_count    = script[i].wc;
      want.last          = 1'b1;
      send_byte(it, script[i].typed, want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_reg(CFG_BIG_ENDIAN, {15'd0, orders[p]});
      set_reg(CFG_OUT_CAPACITY, caps[p]);
      idle_pct = (p == 0) ? 0 : 20;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if (text_q.size() == 0) build_string();
        it = text_q.pop_front();
        sent++;
        send_byte(it, 1'b0, want);
      end
    end
    drain();

    if (mismatches == 0 && words_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
